>>> rtl/core/pel_pkg.sv
// Package for the positional list engine: sizes, operation codes and the
// command and status structs shared by the controller and the datapath.
// Depends on nothing.
`default_nettype none

package pel_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int MODE_W   = 2;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    // signed compare width that holds both a position and a length
    localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    typedef struct packed {
        logic capture;   // latch the accepted transaction
        logic read_pos;  // read the entry at the requested position
        logic start;     // set up the shift walk
        logic step;      // advance the shift walk by one entry
        logic fill;      // update the length and, for an insert, write the new value
        logic load_out;  // load the result register
    } dp_cmd_t;

    typedef struct packed {
        logic legal;       // operation is valid for the current list
        logic is_find;     // operation is a find
        logic shift_done;  // shift walk has no read or write left
        logic out_free;    // result register can take a new result
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/positional_list_engine.sv
// Positional list engine: one find, insert or delete per transaction.
// A find or an error goes from evaluate straight to the result load; an insert
// or delete first walks the shifted entries and then updates the length and,
// for an insert, writes the new value. The next transaction is taken the cycle
// after the result is loaded. Reset empties the list.
`default_nettype none

module positional_list_engine import pel_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    // operation channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [POS_W-1:0]  position,
    input  logic signed [DATA_W-1:0] new_value,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     status,
    output logic signed [DATA_W-1:0] found_value,
    output logic [LEN_W-1:0]         length
);

    // Command and status between the sequencer and the datapath. The
    // controller steps through evaluate, shift walk, fill and result load;
    // the datapath holds the operands, the memory and the length.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each transaction; hold in_ready low until the result is
    // loaded into the output register, which frees the next accept even
    // while that result still waits for out_ready.
    pel_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Insert shifts entries up from the tail down to the slot after the
    // position, then writes the new value; delete shifts entries down from
    // just past the position to the tail. Each step reads one entry and
    // writes the previous one, so the walk is pipelined one entry a cycle.
    pel_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .position    (position),
        .new_value   (new_value),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .status      (status),
        .found_value (found_value),
        .length      (length)
    );

endmodule

`default_nettype wire

>>> rtl/core/pel_controller.sv
// Controller state machine of the positional list engine.
// Depends on pel_pkg for the command and status structs.
`default_nettype none

module pel_controller import pel_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!stat.legal || stat.is_find)
                begin
                    cmd.read_pos = stat.legal;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.step = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pel_datapath.sv
// Datapath of the positional list engine: operand registers, element memory,
// shift walk counter, length register and result register.
// Depends on pel_pkg for sizes, operation codes and the command structs.
`default_nettype none

module pel_datapath import pel_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [POS_W-1:0]  position,
    input  logic signed [DATA_W-1:0] new_value,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic                     status,
    output logic signed [DATA_W-1:0] found_value,
    output logic [LEN_W-1:0]         length
);

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [MODE_W-1:0]        mode_reg;
    logic signed [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0]        val_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [ADDR_W-1:0]        idx_reg;
    logic [ADDR_W-1:0]        wr_addr_reg;
    logic                     reads_left_reg;
    logic                     pend_reg;
    logic                     commit_reg;
    logic [DATA_W-1:0]        rd_data_reg;
    logic                     out_valid_reg;
    logic                     status_reg;
    logic [DATA_W-1:0]        found_reg;
    logic [LEN_W-1:0]         length_reg;

    logic signed [CMP_W-1:0]  pos_x;
    logic signed [CMP_W-1:0]  dst_x;
    logic signed [CMP_W-1:0]  len_x;
    logic [LEN_W-1:0]         len_m1;
    logic [ADDR_W-1:0]        pos_a;
    logic [ADDR_W-1:0]        dst_a;
    logic [ADDR_W-1:0]        last_a;
    logic                     is_find;
    logic                     is_ins;
    logic                     is_del;
    logic                     in_list;
    logic                     legal;

    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;

    always_comb
    begin
        pos_x   = {{(CMP_W - POS_W){pos_reg[POS_W-1]}}, pos_reg};
        dst_x   = pos_x + CMP_W'(1);
        len_x   = {{(CMP_W - LEN_W){1'b0}}, len_reg};
        len_m1  = len_reg - LEN_W'(1);
        pos_a   = pos_x[ADDR_W-1:0];
        dst_a   = dst_x[ADDR_W-1:0];
        is_find = (mode_reg == MODE_FIND);
        is_ins  = (mode_reg == MODE_INSERT);
        is_del  = (mode_reg == MODE_DELETE);
        in_list = !pos_x[CMP_W-1] && (pos_x < len_x);
        legal   = ((is_find || is_del) && in_list)
                  || (is_ins && !dst_x[CMP_W-1] && (pos_x < len_x)
                      && (len_reg < LEN_W'(CAPACITY)));
        last_a  = is_ins ? dst_a : len_m1[ADDR_W-1:0];
    end

    // memory port selection
    always_comb
    begin
        rd_en   = cmd.read_pos || (cmd.step && reads_left_reg);
        rd_addr = cmd.read_pos ? pos_a : idx_reg;
        wr_en   = 1'b0;
        wr_addr = wr_addr_reg;
        wr_data = rd_data_reg;
        if (cmd.step && pend_reg)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.fill && is_ins)
        begin
            wr_en   = 1'b1;
            wr_addr = dst_a;
            wr_data = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            pos_reg  <= position;
            val_reg  <= new_value;
        end
        if (cmd.step && reads_left_reg)
        begin
            wr_addr_reg <= is_ins ? (idx_reg + ADDR_W'(1)) : (idx_reg - ADDR_W'(1));
        end
        if (cmd.load_out)
        begin
            // fill has already moved the length, so a finished insert or
            // delete may no longer test as legal; use the commit flag as well
            status_reg <= !(legal || commit_reg);
            found_reg  <= (is_find && legal) ? rd_data_reg : '0;
            length_reg <= len_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            idx_reg        <= '0;
            reads_left_reg <= 1'b0;
            pend_reg       <= 1'b0;
            commit_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                reads_left_reg <= is_ins ? (len_x > dst_x) : (dst_x < len_x);
                idx_reg        <= is_ins ? len_m1[ADDR_W-1:0] : dst_a;
                pend_reg       <= 1'b0;
            end
            else if (cmd.step)
            begin
                pend_reg <= reads_left_reg;
                if (reads_left_reg)
                begin
                    idx_reg        <= is_ins ? (idx_reg - ADDR_W'(1))
                                             : (idx_reg + ADDR_W'(1));
                    reads_left_reg <= (idx_reg != last_a);
                end
            end
            if (cmd.capture)
            begin
                commit_reg <= 1'b0;
            end
            else if (cmd.fill)
            begin
                commit_reg <= 1'b1;
            end
            if (cmd.fill)
            begin
                if (is_ins)
                begin
                    len_reg <= len_reg + LEN_W'(1);
                end
                else if (is_del)
                begin
                    len_reg <= len_m1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.legal      = legal;
    assign stat.is_find    = is_find;
    assign stat.shift_done = !reads_left_reg && !pend_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_reg;
    assign length      = length_reg;

endmodule

`default_nettype wire

>>> sim/pel_result_checker.sv
// Checker for the positional list engine: watches both channels, keeps its own
// copy of the list and compares every result with the answer it predicts.
// Depends on pel_pkg for sizes and operation codes.
`default_nettype none

module pel_result_checker import pel_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [POS_W-1:0]  position,
    input  logic signed [DATA_W-1:0] new_value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic                     status,
    input  logic signed [DATA_W-1:0] found_value,
    input  logic [LEN_W-1:0]         length,
    output int                       fail_count,
    output int                       pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] found_value;
        logic [LEN_W-1:0]         length;
    } list_answer_t;

    logic signed [DATA_W-1:0] shadow_list [CAPACITY];
    int                       shadow_len;
    list_answer_t             answers_due [$];
    list_answer_t             oldest;
    list_answer_t             fresh;

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        shadow_len    = 0;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("%0t ns: mismatch on %s, expected %0h, got %0h", $realtime, what, want, got);
        fail_count++;
    endtask

    // Apply one operation to the shadow list and work out its answer.
    task automatic apply_list_op(input logic [MODE_W-1:0] op,
                                 input logic signed [POS_W-1:0] where,
                                 input logic signed [DATA_W-1:0] value,
                                 output list_answer_t answer);
        int pos;
        int k;
        pos                = where;
        answer.status      = 1'b1;
        answer.found_value = '0;
        case (op)
            MODE_FIND:
            begin
                if (pos >= 0 && pos < shadow_len)
                begin
                    answer.found_value = shadow_list[pos];
                    answer.status      = 1'b0;
                end
            end
            MODE_INSERT:
            begin
                if (pos >= -1 && pos < shadow_len && shadow_len < CAPACITY)
                begin
                    for (k = shadow_len; k > pos + 1; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[pos+1] = value;
                    shadow_len++;
                    answer.status = 1'b0;
                end
            end
            MODE_DELETE:
            begin
                if (shadow_len > 0 && pos >= 0 && pos < shadow_len)
                begin
                    for (k = pos; k + 1 < shadow_len; k++)
                        shadow_list[k] = shadow_list[k+1];
                    shadow_len--;
                    answer.status = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        answer.length = shadow_len[LEN_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len = 0;
            answers_due.delete();
            pending_count = 0;
        end
        else
        begin
            // a result always belongs to an earlier transaction, so check first
            if (out_valid && out_ready)
            begin
                if (answers_due.size() == 0)
                    report_mismatch("result with nothing outstanding", '0, '0);
                else
                begin
                    oldest = answers_due.pop_front();
                    if (status !== oldest.status)
                        report_mismatch("status", oldest.status, status);
                    if (found_value !== oldest.found_value)
                        report_mismatch("found_value", oldest.found_value, found_value);
                    if (length !== oldest.length)
                        report_mismatch("length", oldest.length, length);
                end
            end
            if (in_valid && in_ready)
            begin
                apply_list_op(mode, position, new_value, fresh);
                answers_due.push_back(fresh);
            end
            pending_count = answers_due.size();
        end
    end

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Top of the positional list engine bench: clock, reset, operation stimulus,
// result back-pressure and the verdict. Depends on pel_pkg, pel_result_checker
// and the positional_list_engine RTL.
`default_nettype none

module testbench import pel_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // mode 3 has no operation behind it and must come back as an error
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    localparam int RANDOM_OPS     = 750;
    localparam int MAX_WAIT       = 12;
    localparam int HOLDOFF_AT     = 120;  // results taken before the long hold-off
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 25;   // wait after the drain before the verdict

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [MODE_W-1:0]        mode;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] new_value;
    logic                     out_valid;
    logic                     out_ready;
    logic                     status;
    logic signed [DATA_W-1:0] found_value;
    logic [LEN_W-1:0]         length;

    int fail_count;
    int pending_count;

    // Length the list should have, kept only to steer the stimulus towards
    // legal positions; all checking lives in the checker.
    int fill_level;

    positional_list_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .position   (position),
        .new_value  (new_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found_value(found_value),
        .length     (length)
    );

    pel_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .position     (position),
        .new_value    (new_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_value  (found_value),
        .length       (length),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // 4 ns period
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Draw how many cycles to wait before the next transaction. Now and then
    // start a calm stretch in which nothing waits at all.
    task automatic draw_wait(inout int calm_left, output int cycles);
        if (calm_left > 0)
        begin
            calm_left--;
            cycles = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(10, 30);
            cycles    = 0;
        end
        else
            cycles = $urandom_range(0, MAX_WAIT);
    endtask

    int sender_calm;

    // Offer one operation and hold it until the engine takes the transaction.
    // Valid is only dropped when a gap is wanted, so back-to-back transactions
    // keep it high across the boundary.
    task automatic send_op(input logic [MODE_W-1:0] op, input int pos,
                           input logic signed [DATA_W-1:0] value);
        int gap;
        draw_wait(sender_calm, gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= op;
        position  <= pos[POS_W-1:0];
        new_value <= value;
        do
            @(posedge clk);
        while (!in_ready);
        // track the length that a legal operation leaves behind
        if (op == MODE_INSERT && pos >= -1 && pos < fill_level && fill_level < CAPACITY)
            fill_level++;
        else if (op == MODE_DELETE && pos >= 0 && pos < fill_level)
            fill_level--;
    endtask

    // Pick a value, leaning now and then on the edges of the 32-bit range.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Result side: stall at random before each result, and once hold off for
    // a long stretch so that the engine backs up and stops taking input.
    initial
    begin : result_sink
        int stall;
        int taken;
        int calm;
        taken = 0;
        calm  = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == HOLDOFF_AT)
                stall = HOLDOFF_CYCLES;
            else
                draw_wait(calm, stall);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    // Operation side: directed opening, then random phases of growth and
    // shrinkage so that the list sweeps between empty and full.
    initial
    begin : op_source
        int                 i;
        int                 raw;
        int                 pos;
        int                 pick;
        bit                 growing;
        logic [MODE_W-1:0]  op;

        in_valid    = 1'b0;
        mode        = MODE_FIND;
        position    = '0;
        new_value   = '0;
        out_ready   = 1'b0;
        rst_n       = 1'b0;
        fill_level  = 0;
        sender_calm = 0;
        growing     = 1'b1;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // empty list: find and delete must both be refused
        send_op(MODE_FIND,   0, pick_value());
        send_op(MODE_DELETE, 0, pick_value());
        // build [0, min, max, -1] using head and tail inserts
        send_op(MODE_INSERT, -1, VALUE_MIN);
        send_op(MODE_INSERT,  0, VALUE_MAX);
        send_op(MODE_INSERT, -1, '0);
        send_op(MODE_INSERT,  2, -1);
        // inserts with the position out of range
        send_op(MODE_INSERT,   4, 32'sh1234_5678);
        send_op(MODE_INSERT,  -2, 32'sh1234_5678);
        send_op(MODE_INSERT, -16, 32'sh1234_5678);
        // read every entry back, then read outside the list
        for (i = 0; i < 4; i++)
            send_op(MODE_FIND, i, pick_value());
        send_op(MODE_FIND,   4, '0);
        send_op(MODE_FIND,  -1, '0);
        send_op(MODE_FIND,  15, '0);
        // the unused mode, and deletes outside the list
        send_op(MODE_UNUSED, 0, '0);
        send_op(MODE_DELETE, 4, '0);
        send_op(MODE_DELETE, -1, '0);
        // drop the head, then the tail, then append and read it back
        send_op(MODE_DELETE, 0, '0);
        send_op(MODE_DELETE, 2, '0);
        send_op(MODE_INSERT, 1, 32'sh5555_aaaa);
        send_op(MODE_FIND,   2, '0);

        for (i = 0; i < RANDOM_OPS; i++)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                // noise: any mode, any position the field can carry
                op  = MODE_W'($urandom_range(0, 3));
                raw = $urandom_range(0, 31);
                pos = (raw >= 16) ? raw - 32 : raw;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (growing)
                    op = (pick < 60) ? MODE_INSERT : (pick < 85) ? MODE_FIND : MODE_DELETE;
                else
                    op = (pick < 60) ? MODE_DELETE : (pick < 85) ? MODE_FIND : MODE_INSERT;
                if (op == MODE_INSERT)
                begin
                    pos = $urandom_range(0, fill_level);
                    pos = pos - 1;
                end
                else if (fill_level > 0)
                    pos = $urandom_range(0, fill_level - 1);
                else
                    pos = 0;
            end
            send_op(op, pos, pick_value());
            // linger at full and empty for a while before turning round
            if (fill_level == CAPACITY && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (fill_level == 0 && $urandom_range(0, 3) == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                growing = !growing;
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain outstanding results, then let the engine settle
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> positional_list_engine.f
rtl/core/pel_pkg.sv
rtl/core/pel_controller.sv
rtl/core/pel_datapath.sv
rtl/core/positional_list_engine.sv
sim/pel_result_checker.sv
sim/testbench.sv
